// ===== sv/e2rm_pkg.sv =====
// Shared types, constants and arithmetic helpers for the Euler angle to rotation matrix block.
`timescale 1ns / 1ps

package e2rm_pkg;

    localparam int ANGLE_BITS_DEFAULT       = 16;
    localparam int MATRIX_FRAC_BITS_DEFAULT = 14;
    localparam int FIELD_BITS               = 16;
    localparam int CORDIC_ITERS             = 30;
    localparam int Q30_BITS                 = 33;
    localparam logic signed [Q30_BITS-1:0] CORDIC_START = 33'sd652032874;

    typedef logic signed [Q30_BITS-1:0] e2rm_q30_t;

    // One angle in flight through the rotation chain.
    typedef struct packed {
        e2rm_q30_t x;
        e2rm_q30_t y;
        e2rm_q30_t z;
        logic      flip;
    } e2rm_rot_t;

    typedef struct packed {
        e2rm_rot_t roll;
        e2rm_rot_t pitch;
        e2rm_rot_t yaw;
    } e2rm_trio_t;

    typedef struct packed {
        logic [FIELD_BITS-1:0] m00;
        logic [FIELD_BITS-1:0] m01;
        logic [FIELD_BITS-1:0] m02;
        logic [FIELD_BITS-1:0] m10;
        logic [FIELD_BITS-1:0] m11;
        logic [FIELD_BITS-1:0] m12;
        logic [FIELD_BITS-1:0] m20;
        logic [FIELD_BITS-1:0] m21;
        logic [FIELD_BITS-1:0] m22;
    } e2rm_mat_t;

    // Arctangent of 2^-idx, with one turn equal to 2^32.
    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2F9;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            5'd24:   v = 32'h00000029;
            5'd25:   v = 32'h00000014;
            5'd26:   v = 32'h0000000A;
            5'd27:   v = 32'h00000005;
            5'd28:   v = 32'h00000003;
            5'd29:   v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    // Q1.30 product rounded half up back to Q1.30.
    function automatic e2rm_q30_t qmul(input e2rm_q30_t a, input e2rm_q30_t b);
        logic signed [2*Q30_BITS-1:0] p;
        p = a * b;
        p = p + (66'sd1 <<< 29);
        return p[Q30_BITS+29:30];
    endfunction

endpackage

// ===== sv/e2rm_angle_if.sv =====
// Channel carrying one set of three Euler angles.
`timescale 1ns / 1ps

interface e2rm_angle_if;
    logic        valid;
    logic        ready;
    logic [15:0] roll_angle;
    logic [15:0] pitch_angle;
    logic [15:0] yaw_angle;

    modport source (output valid, roll_angle, pitch_angle, yaw_angle, input ready);
    modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

// ===== sv/e2rm_matrix_if.sv =====
// Channel carrying the nine entries of one rotation matrix.
`timescale 1ns / 1ps

interface e2rm_matrix_if;
    logic        valid;
    logic        ready;
    logic [15:0] m00;
    logic [15:0] m01;
    logic [15:0] m02;
    logic [15:0] m10;
    logic [15:0] m11;
    logic [15:0] m12;
    logic [15:0] m20;
    logic [15:0] m21;
    logic [15:0] m22;

    modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    input ready);
    modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    output ready);
endinterface

// ===== sv/e2rm_cordic_cell.sv =====
// One CORDIC iteration for all three angles, registered, with its own valid bit.
`timescale 1ns / 1ps

module e2rm_cordic_cell #(
    parameter int ITER = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  e2rm_pkg::e2rm_trio_t in_data,
    output logic                up_ready,
    input  logic                down_ready,
    output logic                out_valid,
    output e2rm_pkg::e2rm_trio_t out_data
);

    localparam logic signed [e2rm_pkg::Q30_BITS-1:0] ATAN =
        $signed({1'b0, e2rm_pkg::atan_turn(5'(ITER))});

    logic                 valid_reg;
    logic                 valid_next;
    e2rm_pkg::e2rm_trio_t data_reg;
    e2rm_pkg::e2rm_trio_t data_next;

    function automatic e2rm_pkg::e2rm_rot_t rotate(input e2rm_pkg::e2rm_rot_t r);
        e2rm_pkg::e2rm_rot_t o;
        e2rm_pkg::e2rm_q30_t dx;
        e2rm_pkg::e2rm_q30_t dy;
        dx = $signed(r.y) >>> ITER;
        dy = $signed(r.x) >>> ITER;
        o  = r;
        if (!r.z[e2rm_pkg::Q30_BITS-1])
        begin
            o.x = $signed(r.x) - dx;
            o.y = $signed(r.y) + dy;
            o.z = $signed(r.z) - ATAN;
        end
        else
        begin
            o.x = $signed(r.x) + dx;
            o.y = $signed(r.y) - dy;
            o.z = $signed(r.z) + ATAN;
        end
        return o;
    endfunction

    assign up_ready = !valid_reg || down_ready;

    always_comb
    begin
        valid_next      = up_ready ? in_valid : valid_reg;
        data_next       = data_reg;
        if (up_ready && in_valid)
        begin
            data_next.roll  = rotate(in_data.roll);
            data_next.pitch = rotate(in_data.pitch);
            data_next.yaw   = rotate(in_data.yaw);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== sv/e2rm_matrix_stage.sv =====
// Three registered stages that form the products, sums and rounded matrix entries.
`timescale 1ns / 1ps

module e2rm_matrix_stage #(
    parameter int MATRIX_FRAC_BITS = e2rm_pkg::MATRIX_FRAC_BITS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  e2rm_pkg::e2rm_trio_t in_data,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output e2rm_pkg::e2rm_mat_t  out_data
);

    localparam int SH = 30 - MATRIX_FRAC_BITS;
    localparam logic signed [35:0] RND = (36'sd1 <<< SH) >>> 1;
    localparam logic signed [35:0] ONE = 36'sd1 <<< MATRIX_FRAC_BITS;

    typedef logic signed [e2rm_pkg::Q30_BITS-1:0] q_t;

    // Sum in Q1.30 to output format, rounded half up and clamped to plus or minus one.
    function automatic logic [15:0] finish(input logic signed [35:0] v);
        logic signed [35:0] r;
        r = (v + RND) >>> SH;
        if (r > ONE)
        begin
            r = ONE;
        end
        if (r < -ONE)
        begin
            r = -ONE;
        end
        return r[15:0];
    endfunction

    q_t cx, sx, cy, sy, cz, sz;

    logic v1_reg, v2_reg, v3_reg;
    logic r1, r2, r3;

    q_t czsy_reg, szsy_reg, czcy_reg, szcx_reg, szsx_reg, szcy_reg;
    q_t czcx_reg, czsx_reg, cysx_reg, cycx_reg, sy1_reg, cx_reg, sx_reg;

    q_t a01_reg, a02_reg, a11_reg, a12_reg;
    q_t b01_reg, b02_reg, b11_reg, b12_reg;
    q_t czcy2_reg, szcy2_reg, cysx2_reg, cycx2_reg, sy2_reg;

    e2rm_pkg::e2rm_mat_t mat_reg;

    // The CORDIC ran on the half turn around zero; undo the added half turn.
    assign cx = in_data.roll.flip  ? -$signed(in_data.roll.x)  : $signed(in_data.roll.x);
    assign sx = in_data.roll.flip  ? -$signed(in_data.roll.y)  : $signed(in_data.roll.y);
    assign cy = in_data.pitch.flip ? -$signed(in_data.pitch.x) : $signed(in_data.pitch.x);
    assign sy = in_data.pitch.flip ? -$signed(in_data.pitch.y) : $signed(in_data.pitch.y);
    assign cz = in_data.yaw.flip   ? -$signed(in_data.yaw.x)   : $signed(in_data.yaw.x);
    assign sz = in_data.yaw.flip   ? -$signed(in_data.yaw.y)   : $signed(in_data.yaw.y);

    assign r3       = !v3_reg || out_ready;
    assign r2       = !v2_reg || r3;
    assign r1       = !v1_reg || r2;
    assign in_ready = r1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (r1)
            begin
                v1_reg <= in_valid;
            end
            if (r2)
            begin
                v2_reg <= v1_reg;
            end
            if (r3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (r1 && in_valid)
        begin
            czsy_reg <= e2rm_pkg::qmul(cz, sy);
            szsy_reg <= e2rm_pkg::qmul(sz, sy);
            czcy_reg <= e2rm_pkg::qmul(cz, cy);
            szcx_reg <= e2rm_pkg::qmul(sz, cx);
            szsx_reg <= e2rm_pkg::qmul(sz, sx);
            szcy_reg <= e2rm_pkg::qmul(sz, cy);
            czcx_reg <= e2rm_pkg::qmul(cz, cx);
            czsx_reg <= e2rm_pkg::qmul(cz, sx);
            cysx_reg <= e2rm_pkg::qmul(cy, sx);
            cycx_reg <= e2rm_pkg::qmul(cy, cx);
            sy1_reg  <= sy;
            cx_reg   <= cx;
            sx_reg   <= sx;
        end
        if (r2 && v1_reg)
        begin
            a01_reg   <= e2rm_pkg::qmul(czsy_reg, sx_reg);
            a02_reg   <= e2rm_pkg::qmul(czsy_reg, cx_reg);
            a11_reg   <= e2rm_pkg::qmul(szsy_reg, sx_reg);
            a12_reg   <= e2rm_pkg::qmul(szsy_reg, cx_reg);
            b01_reg   <= szcx_reg;
            b02_reg   <= szsx_reg;
            b11_reg   <= czcx_reg;
            b12_reg   <= czsx_reg;
            czcy2_reg <= czcy_reg;
            szcy2_reg <= szcy_reg;
            cysx2_reg <= cysx_reg;
            cycx2_reg <= cycx_reg;
            sy2_reg   <= sy1_reg;
        end
        if (r3 && v2_reg)
        begin
            mat_reg.m00 <= finish(36'(czcy2_reg));
            mat_reg.m01 <= finish(36'(a01_reg) - 36'(b01_reg));
            mat_reg.m02 <= finish(36'(a02_reg) + 36'(b02_reg));
            mat_reg.m10 <= finish(36'(szcy2_reg));
            mat_reg.m11 <= finish(36'(a11_reg) + 36'(b11_reg));
            mat_reg.m12 <= finish(36'(a12_reg) - 36'(b12_reg));
            mat_reg.m20 <= finish(-36'(sy2_reg));
            mat_reg.m21 <= finish(36'(cysx2_reg));
            mat_reg.m22 <= finish(36'(cycx2_reg));
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = mat_reg;

endmodule

// ===== sv/euler_angles_to_rotation_matrix.sv =====
// Top level: Euler angles (Z-Y-X) to rotation matrix, CORDIC chain plus product stages.
`timescale 1ns / 1ps

// Takes roll, pitch and yaw as binary angles and returns Rz*Ry*Rx in signed
// fixed point with MATRIX_FRAC_BITS fraction bits, clamped to plus or minus one.
// Sine and cosine come from a row of 30 CORDIC cells, one iteration each, that
// works all three angles side by side; three product and rounding stages follow.
// A transfer is accepted every cycle while the output side keeps up. The item
// passes 33 register stages, 30 CORDIC cells and three product stages, and the
// first of them loads at the input transfer. Any stage that holds no item lets
// the stages behind it advance.

module euler_angles_to_rotation_matrix #(
    parameter int ANGLE_BITS       = e2rm_pkg::ANGLE_BITS_DEFAULT,
    parameter int MATRIX_FRAC_BITS = e2rm_pkg::MATRIX_FRAC_BITS_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    e2rm_angle_if.sink    angles,
    e2rm_matrix_if.source matrix
);

    localparam int N = e2rm_pkg::CORDIC_ITERS;

    logic                 cell_valid [0:N];
    logic                 cell_ready [0:N];
    e2rm_pkg::e2rm_trio_t cell_data  [0:N];
    e2rm_pkg::e2rm_mat_t  mat;

    // Scale to one turn = 2^32 and fold the left half plane onto the right one.
    function automatic e2rm_pkg::e2rm_rot_t prep(input logic [15:0] field);
        e2rm_pkg::e2rm_rot_t r;
        logic [31:0]         a;
        a      = 32'(field) << (32 - ANGLE_BITS);
        r.flip = a[31] ^ a[30];
        if (r.flip)
        begin
            a = a + 32'h80000000;
        end
        r.x = e2rm_pkg::CORDIC_START;
        r.y = '0;
        r.z = $signed({a[31], a});
        return r;
    endfunction

    assign cell_valid[0]      = angles.valid;
    assign cell_data[0].roll  = prep(angles.roll_angle);
    assign cell_data[0].pitch = prep(angles.pitch_angle);
    assign cell_data[0].yaw   = prep(angles.yaw_angle);
    assign angles.ready       = cell_ready[0];

    for (genvar k = 0; k < N; k++)
    begin : g_cell
        e2rm_cordic_cell #(
            .ITER(k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (cell_valid[k]),
            .in_data   (cell_data[k]),
            .up_ready  (cell_ready[k]),
            .down_ready(cell_ready[k+1]),
            .out_valid (cell_valid[k+1]),
            .out_data  (cell_data[k+1])
        );
    end

    e2rm_matrix_stage #(
        .MATRIX_FRAC_BITS(MATRIX_FRAC_BITS)
    ) u_matrix (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cell_valid[N]),
        .in_data  (cell_data[N]),
        .in_ready (cell_ready[N]),
        .out_valid(matrix.valid),
        .out_ready(matrix.ready),
        .out_data (mat)
    );

    assign matrix.m00 = mat.m00;
    assign matrix.m01 = mat.m01;
    assign matrix.m02 = mat.m02;
    assign matrix.m10 = mat.m10;
    assign matrix.m11 = mat.m11;
    assign matrix.m12 = mat.m12;
    assign matrix.m20 = mat.m20;
    assign matrix.m21 = mat.m21;
    assign matrix.m22 = mat.m22;

    // An empty output register frees every stage behind it.
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !matrix.valid |-> angles.ready)
        else $error("input stalled although output register is empty");

    a_first_cell_loads: assert property (@(posedge clk) disable iff (!rst_n)
        angles.valid && angles.ready |=> cell_valid[1])
        else $error("accepted transfer did not reach the first cell");

    a_m20_range: assert property (@(posedge clk) disable iff (!rst_n)
        matrix.valid |-> (MATRIX_FRAC_BITS > 14)
            || ($signed(matrix.m20) <= $signed(17'(1 << MATRIX_FRAC_BITS))
                && $signed(matrix.m20) >= -$signed(17'(1 << MATRIX_FRAC_BITS))))
        else $error("matrix entry outside plus or minus one");

endmodule

// ===== test/tb_e2rm_channels.sv =====
// Testbench-side note: the channel interfaces come from the RTL files; this file holds the test stimulus types.
`timescale 1ns / 1ps

package tb_e2rm_types;

    typedef struct packed {
        logic [15:0] roll;
        logic [15:0] pitch;
        logic [15:0] yaw;
    } angle_set_t;

endpackage

// ===== test/tb_euler_angles_to_rotation_matrix.sv =====
// Self-checking testbench for the Euler angle to rotation matrix block.
`timescale 1ns / 1ps

module tb_euler_angles_to_rotation_matrix;

    localparam int LATENCY = 33;

    logic clk;
    logic rst_n;

    e2rm_angle_if  angles ();
    e2rm_matrix_if matrix ();

    euler_angles_to_rotation_matrix dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .angles (angles.sink),
        .matrix (matrix.source)
    );

    tb_e2rm_types::angle_set_t pending_angles[$];
    e2rm_pkg::e2rm_mat_t       expected_matrices[$];
    int         error_count;
    int         accepted_count;
    int         total_items;
    bit         stimulus_done;
    bit         calm_phase;
    bit         drain_pause;
    bit         hold_request;
    bit         hold_off;
    int         send_gap;
    int         recv_gap;

    // Sine and cosine of one binary angle by rotation-mode CORDIC, Q1.30.
    task automatic cordic_sincos(input logic [15:0] field,
                                 output longint cosv, output longint sinv);
        logic [31:0] a;
        logic [1:0]  top;
        bit          flip;
        longint      x, y, z, dx, dy, step;
        a = {field, 16'h0000};
        top = a[31:30];
        flip = (top == 2'b01) || (top == 2'b10);
        if (flip)
        begin
            a = a + 32'h80000000;
        end
        x = 652032874;
        y = 0;
        z = longint'($signed(a));
        for (int i = 0; i < e2rm_pkg::CORDIC_ITERS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            step = longint'(e2rm_pkg::atan_turn(i[4:0]));
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - step;
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + step;
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        cosv = x;
        sinv = y;
    endtask

    function automatic longint q30_product(input longint a, input longint b);
        return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    // Rounds a Q1.30 sum to Q2.14 and clamps it to plus or minus one.
    function automatic logic [15:0] to_q2_14(input longint v);
        longint r;
        r = (v + (64'sd1 <<< 15)) >>> 16;
        if (r > 16384)
        begin
            r = 16384;
        end
        if (r < -16384)
        begin
            r = -16384;
        end
        return r[15:0];
    endfunction

    task automatic predict_rotation(input tb_e2rm_types::angle_set_t s,
                                    output e2rm_pkg::e2rm_mat_t m);
        longint cx, sx, cy, sy, cz, sz, czsy, szsy;
        cordic_sincos(s.roll, cx, sx);
        cordic_sincos(s.pitch, cy, sy);
        cordic_sincos(s.yaw, cz, sz);
        czsy = q30_product(cz, sy);
        szsy = q30_product(sz, sy);
        m.m00 = to_q2_14(q30_product(cz, cy));
        m.m01 = to_q2_14(q30_product(czsy, sx) - q30_product(sz, cx));
        m.m02 = to_q2_14(q30_product(czsy, cx) + q30_product(sz, sx));
        m.m10 = to_q2_14(q30_product(sz, cy));
        m.m11 = to_q2_14(q30_product(szsy, sx) + q30_product(cz, cx));
        m.m12 = to_q2_14(q30_product(szsy, cx) - q30_product(cz, sx));
        m.m20 = to_q2_14(-sy);
        m.m21 = to_q2_14(q30_product(cy, sx));
        m.m22 = to_q2_14(q30_product(cy, cx));
    endtask

    function automatic logic [15:0] random_angle();
        logic [15:0] v;
        case ($urandom_range(0, 5))
            0:       v = 16'h8000 + 16'($urandom_range(0, 3)) - 16'd2;
            1:       v = 16'h4000 + 16'($urandom_range(0, 3)) - 16'd2;
            2:       v = 16'hC000 + 16'($urandom_range(0, 3)) - 16'd2;
            3:       v = 16'($urandom_range(0, 7)) - 16'd4;
            default: v = 16'($urandom());
        endcase
        return v;
    endfunction

    task automatic queue_angles(input logic [15:0] r, input logic [15:0] p,
                                input logic [15:0] y);
        tb_e2rm_types::angle_set_t s;
        s.roll = r;
        s.pitch = p;
        s.yaw = y;
        pending_angles.push_back(s);
        total_items++;
    endtask

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // Long receiver hold-off, counted here in cycles.
    initial
    begin
        hold_off = 1'b0;
        wait (hold_request);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (120) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        logic [15:0] corners[8];
        corners = '{16'h0000, 16'h7FFF, 16'h8000, 16'h4000,
                    16'hC000, 16'h3FFF, 16'hBFFF, 16'h2000};
        rst_n = 1'b0;
        error_count = 0;
        total_items = 0;
        stimulus_done = 1'b0;
        calm_phase = 1'b0;
        drain_pause = 1'b0;
        // Directed: quadrant edges, -pi, full-scale patterns on each axis.
        for (int i = 0; i < 8; i++)
        begin
            queue_angles(corners[i], corners[(i + 3) % 8], corners[(i + 5) % 8]);
        end
        queue_angles(16'h8000, 16'h8000, 16'h8000);
        queue_angles(16'h7FFF, 16'h7FFF, 16'h7FFF);
        queue_angles(16'hFFFF, 16'h0001, 16'h5555);
        queue_angles(16'hAAAA, 16'h5555, 16'hFFFF);
        queue_angles(16'h0000, 16'h4000, 16'h0000);
        queue_angles(16'h0000, 16'hC000, 16'h1234);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        // First random batch; receiver holds off long so the pipeline backs up.
        for (int i = 0; i < 200; i++)
        begin
            queue_angles(random_angle(), random_angle(), random_angle());
        end
        wait (pending_angles.size() < 150);
        hold_request = 1'b1;
        wait (pending_angles.size() == 0);
        // The sender pauses until every result has come.
        drain_pause = 1'b1;
        wait (expected_matrices.size() == 0);
        @(posedge clk);
        drain_pause = 1'b0;
        for (int i = 0; i < 300; i++)
        begin
            queue_angles(random_angle(), random_angle(), random_angle());
        end
        wait (pending_angles.size() == 0);
        @(posedge clk);
        calm_phase = 1'b1;
        for (int i = 0; i < 136; i++)
        begin
            queue_angles(16'($urandom()), 16'($urandom()), 16'($urandom()));
        end
        wait (pending_angles.size() == 0 && accepted_count == total_items);
        stimulus_done = 1'b1;
        wait (expected_matrices.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);
        if (error_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

    // Driver: offers the head of the queue, with random bursts of idle cycles outside the calm phase.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angles.valid       <= 1'b0;
            angles.roll_angle  <= '0;
            angles.pitch_angle <= '0;
            angles.yaw_angle   <= '0;
            send_gap           <= 0;
            accepted_count     <= 0;
        end
        else
        begin
            tb_e2rm_types::angle_set_t s;
            e2rm_pkg::e2rm_mat_t       m;
            bit          fire;
            bit          offer;
            fire = angles.valid && angles.ready;
            if (fire)
            begin
                s.roll = angles.roll_angle;
                s.pitch = angles.pitch_angle;
                s.yaw = angles.yaw_angle;
                predict_rotation(s, m);
                expected_matrices.push_back(m);
                accepted_count <= accepted_count + 1;
                void'(pending_angles.pop_front());
            end
            offer = 1'b0;
            if (angles.valid && !fire)
            begin
                offer = 1'b1;
            end
            else if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
            end
            else if (!calm_phase && $urandom_range(0, 9) == 0)
            begin
                send_gap <= $urandom_range(1, 19);
            end
            else if (pending_angles.size() > 0 && !drain_pause)
            begin
                offer = 1'b1;
            end
            angles.valid <= offer;
            if (offer && !(angles.valid && !fire))
            begin
                s = pending_angles[0];
                angles.roll_angle  <= s.roll;
                angles.pitch_angle <= s.pitch;
                angles.yaw_angle   <= s.yaw;
            end
        end
    end

    // Monitor: random stalls on the output outside the calm phase, compares each transfer in order.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matrix.ready <= 1'b0;
            recv_gap     <= 0;
        end
        else
        begin
            e2rm_pkg::e2rm_mat_t got;
            e2rm_pkg::e2rm_mat_t want;
            if (matrix.valid && matrix.ready)
            begin
                got = {matrix.m00, matrix.m01, matrix.m02, matrix.m10, matrix.m11,
                       matrix.m12, matrix.m20, matrix.m21, matrix.m22};
                if (expected_matrices.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected matrix %h", $time, got);
                end
                else
                begin
                    want = expected_matrices.pop_front();
                    if (got !== want)
                    begin
                        error_count++;
                        $display("%0t: matrix mismatch expected %h actual %h",
                                 $time, want, got);
                    end
                end
            end
            if (hold_off)
            begin
                matrix.ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                matrix.ready <= 1'b0;
            end
            else if (!calm_phase && $urandom_range(0, 9) == 0)
            begin
                recv_gap <= $urandom_range(1, 19);
                matrix.ready <= 1'b0;
            end
            else
            begin
                matrix.ready <= 1'b1;
            end
        end
    end

endmodule
